### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clocked property, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that a plain expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### rtl/rsh_pkg.sv
// Package with types, constants and helper functions of the spherical harmonic evaluator.
package rsh_pkg;

    // Field widths.
    localparam int DIR_W      = 16;
    localparam int VAL_W      = 18;
    localparam int DEG_W      = 3;
    localparam int ORD_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam int MAX_DEGREE_DEF = 4;

    // Number of pipeline stages from the input register to the output register.
    localparam int NSTG = 7;

    // Internal datapath widths.
    localparam int SQ_W    = 32;            // squares and pair products, Q28
    localparam int COMB_W  = 38;            // polynomial factors before rounding
    localparam int RND7_W  = COMB_W - 6;    // factor rounded from Q28 to Q21
    localparam int OPA_W   = 25;            // first multiplier operand
    localparam int OPB_W   = 34;            // second multiplier operand
    localparam int PROD_W  = OPA_W + OPB_W; // full lane product
    localparam int PRND_W  = 45;            // lane product rounded to Q28
    localparam int SUM_W   = 47;            // polynomial sum
    localparam int POLY_W  = 34;            // clamped polynomial
    localparam int COEF_W  = 23;            // Q20 coefficient
    localparam int FIN_W   = COEF_W + POLY_W;
    localparam int IDX_W   = 6;

    localparam logic signed [COMB_W-1:0] ONE_Q28 = COMB_W'(268435456);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 1'b1;

    // Basis function codes: degree * 9 + order + 4.
    localparam logic [IDX_W-1:0] SH_Y00  = 6'd4;
    localparam logic [IDX_W-1:0] SH_Y1N1 = 6'd12;
    localparam logic [IDX_W-1:0] SH_Y10  = 6'd13;
    localparam logic [IDX_W-1:0] SH_Y1P1 = 6'd14;
    localparam logic [IDX_W-1:0] SH_Y2N2 = 6'd20;
    localparam logic [IDX_W-1:0] SH_Y2N1 = 6'd21;
    localparam logic [IDX_W-1:0] SH_Y20  = 6'd22;
    localparam logic [IDX_W-1:0] SH_Y2P1 = 6'd23;
    localparam logic [IDX_W-1:0] SH_Y2P2 = 6'd24;
    localparam logic [IDX_W-1:0] SH_Y3N3 = 6'd28;
    localparam logic [IDX_W-1:0] SH_Y3N2 = 6'd29;
    localparam logic [IDX_W-1:0] SH_Y3N1 = 6'd30;
    localparam logic [IDX_W-1:0] SH_Y30  = 6'd31;
    localparam logic [IDX_W-1:0] SH_Y3P1 = 6'd32;
    localparam logic [IDX_W-1:0] SH_Y3P2 = 6'd33;
    localparam logic [IDX_W-1:0] SH_Y3P3 = 6'd34;
    localparam logic [IDX_W-1:0] SH_Y4N4 = 6'd36;
    localparam logic [IDX_W-1:0] SH_Y4N3 = 6'd37;
    localparam logic [IDX_W-1:0] SH_Y4N2 = 6'd38;
    localparam logic [IDX_W-1:0] SH_Y4N1 = 6'd39;
    localparam logic [IDX_W-1:0] SH_Y40  = 6'd40;
    localparam logic [IDX_W-1:0] SH_Y4P1 = 6'd41;
    localparam logic [IDX_W-1:0] SH_Y4P2 = 6'd42;
    localparam logic [IDX_W-1:0] SH_Y4P3 = 6'd43;
    localparam logic [IDX_W-1:0] SH_Y4P4 = 6'd44;
    localparam logic [IDX_W-1:0] SH_NONE = 6'd63;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } dir_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] basis_value;
        logic                    bad_order;
    } basis_res_t;

    // Rounds a Q28 value to Q21, to nearest with ties away from zero.
    function automatic logic signed [RND7_W-1:0] rnd7(input logic signed [COMB_W-1:0] v);
        logic [COMB_W:0] mag;
        logic [COMB_W:0] r;
        mag = v[COMB_W-1] ? ((COMB_W+1)'(0) - {v[COMB_W-1], v}) : {v[COMB_W-1], v};
        r = (mag + (COMB_W+1)'(64)) >> 7;
        if (v[COMB_W-1])
        begin
            r = (COMB_W+1)'(0) - r;
        end
        return $signed(r[RND7_W-1:0]);
    endfunction

    // Q20 normalization constant of each basis function.
    function automatic logic signed [COEF_W-1:0] coef_of(input logic [IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            SH_Y00:  c = 23'sd295798;
            SH_Y1N1: c = -23'sd512337;
            SH_Y10:  c = 23'sd512337;
            SH_Y1P1: c = -23'sd512337;
            SH_Y2N2: c = 23'sd1145620;
            SH_Y2N1: c = -23'sd1145620;
            SH_Y20:  c = 23'sd330712;
            SH_Y2P1: c = -23'sd1145620;
            SH_Y2P2: c = 23'sd572810;
            SH_Y3N3: c = -23'sd618706;
            SH_Y3N2: c = 23'sd3031025;
            SH_Y3N1: c = -23'sd479247;
            SH_Y30:  c = 23'sd391303;
            SH_Y3P1: c = -23'sd479247;
            SH_Y3P2: c = 23'sd1515513;
            SH_Y3P3: c = -23'sd618706;
            SH_Y4N4: c = 23'sd2624945;
            SH_Y4N3: c = -23'sd1856117;
            SH_Y4N2: c = 23'sd992136;
            SH_Y4N1: c = -23'sd701547;
            SH_Y40:  c = 23'sd110925;
            SH_Y4P1: c = -23'sd701547;
            SH_Y4P2: c = 23'sd496068;
            SH_Y4P3: c = -23'sd1856117;
            SH_Y4P4: c = 23'sd656237;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/rsh_lane.sv
// Two-stage multiplier lane: registered product, then rounding from Q42 to Q28.
module rsh_lane
    import rsh_pkg::*;
(
    input  logic                     clk,
    input  logic                     mul_en,
    input  logic                     rnd_en,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    output logic signed [PRND_W-1:0] prod_rnd
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PRND_W-1:0] rnd_reg;
    logic signed [PRND_W-1:0] rnd_next;
    logic [PROD_W:0]          mag;
    logic [PROD_W:0]          r;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // Round half away from zero by working on the magnitude.
    always_comb
    begin
        mag = prod_reg[PROD_W-1] ? ((PROD_W+1)'(0) - {prod_reg[PROD_W-1], prod_reg})
                                 : {prod_reg[PROD_W-1], prod_reg};
        r = (mag + (PROD_W+1)'(8192)) >> 14;
        if (prod_reg[PROD_W-1])
        begin
            r = (PROD_W+1)'(0) - r;
        end
        rnd_next = $signed(r[PRND_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (rnd_en)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign prod_rnd = rnd_reg;

endmodule

### rtl/real_sph_harmonic_eval.sv
// Top level of the real spherical harmonic evaluator for degrees 0 to 4.
// Usage: write the band with index CFG_DEGREE and the order with index
// CFG_ORDER on the configuration channel (cfg_valid/cfg_ready, always ready)
// while no transaction is in flight. Then stream unit directions as Q1.14
// triples on the item channel (item_valid/item_stall). Each accepted
// transaction yields exactly one result transaction on the result channel
// (result_valid/result_stall): the basis value in Q1.16, saturated, and a
// bad_order flag that is set, with a zero value, when the order lies outside
// minus degree to degree or the degree exceeds MAX_DEGREE.
// The datapath is a seven-stage pipeline: squares and pair products, factor
// selection and rounding, lane multiply, lane rounding, sum and clamp,
// coefficient multiply, final rounding and saturation. One item enters in
// every cycle in which item_stall is low, and each of the two multiplier
// lanes takes a new operand pair in every cycle in which its stage advances.
// When the receiver stalls, valid bits hold in place and empty stages ahead
// of the stall still fill, so item_stall only rises once every stage is full.
// Reset clears all valid bits and the configuration (degree 0, order 0).
module real_sph_harmonic_eval
    import rsh_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  dir_item_t             item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output basis_res_t            result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [DEG_W-1:0]        degree_reg;
    logic [DEG_W-1:0]        degree_next;
    logic signed [ORD_W-1:0] order_reg;
    logic signed [ORD_W-1:0] order_next;

    // Pipeline control: one valid bit per stage and an advance chain.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   adv;

    // Decoded basis function; the user keeps it stable while transactions are in flight (not enforced).
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic             band4;

    // Stage 1: inputs and their squares and pair products.
    logic signed [DIR_W-1:0] x_reg, y_reg, z_reg;
    logic signed [SQ_W-1:0]  x2_reg, y2_reg, z2_reg, xy_reg, yz_reg, xz_reg;
    logic signed [SQ_W-1:0]  xw, yw, zw;
    logic signed [SQ_W-1:0]  x2_next, y2_next, z2_next, xy_next, yz_next, xz_next;

    // Stage 2: multiplier operands.
    logic signed [COMB_W-1:0] t_x2, t_y2, t_z2;
    logic signed [COMB_W-1:0] c_xmy, c_3xmy, c_xm3y, c_ym3x;
    logic signed [COMB_W-1:0] c_4z, c_2z3, c_2z, c_7z1, c_7z3, c_35z;
    logic signed [COMB_W-1:0] fa, fb, fc, fd;
    logic signed [RND7_W-1:0] ra, rb, rc, rd;
    logic signed [OPA_W-1:0]  opa_reg, opc_reg, opa_next, opc_next;
    logic signed [OPB_W-1:0]  opb_reg, opd_reg, opb_next, opd_next;

    // Stages 3 and 4 live in the lanes.
    logic signed [PRND_W-1:0] pa, pb;

    // Stage 5: polynomial value, clamped.
    logic signed [SUM_W-1:0]  sum;
    logic signed [POLY_W-1:0] poly_reg, poly_next;

    // Stage 6: coefficient product.
    logic signed [FIN_W-1:0] fin_reg, fin_next;

    // Stage 7: output register.
    basis_res_t       result_reg, result_next;
    logic [FIN_W:0]   fmag;
    logic [FIN_W:0]   fr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        degree_next = degree_reg;
        order_next  = order_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEGREE: degree_next = cfg_data[DEG_W-1:0];
                CFG_ORDER:  order_next  = $signed(cfg_data[ORD_W-1:0]);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            order_reg  <= '0;
        end
        else
        begin
            degree_reg <= degree_next;
            order_reg  <= order_next;
        end
    end

    // The pair is evaluable when degree is in range and the order lies
    // within the band. Otherwise the code selects no polynomial and no
    // coefficient, so the result comes out as zero.
    always_comb
    begin
        ok = (int'(degree_reg) <= MAX_DEGREE)
             && (int'(order_reg) <= int'(degree_reg))
             && (-int'(order_reg) <= int'(degree_reg));
        idx = ok ? IDX_W'(int'(degree_reg) * 9 + int'(order_reg) + 4) : SH_NONE;
        band4 = ok && (int'(degree_reg) == 4);
    end

    // A stage moves forward when it is empty or the stage after it moves.
    always_comb
    begin
        adv[NSTG] = !result_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = (k == 0) ? item_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item_stall   = !adv[0];
    assign result_valid = vld_reg[NSTG-1];

    // Stage 1: all six second-order monomials, exact in Q28.
    always_comb
    begin
        xw = SQ_W'(item.dir_x);
        yw = SQ_W'(item.dir_y);
        zw = SQ_W'(item.dir_z);
        x2_next = xw * xw;
        y2_next = yw * yw;
        z2_next = zw * zw;
        xy_next = xw * yw;
        yz_next = yw * zw;
        xz_next = xw * zw;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_reg  <= item.dir_x;
            y_reg  <= item.dir_y;
            z_reg  <= item.dir_z;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            z2_reg <= z2_next;
            xy_reg <= xy_next;
            yz_reg <= yz_next;
            xz_reg <= xz_next;
        end
    end

    // Stage 2: pick the two factors of the polynomial. Bands 0 and 2 use a
    // factor of 2^14 and band 1 a factor of 2^28, so that the lane rounding
    // leaves the value exact; band 3 multiplies a raw coordinate by a Q28
    // term; band 4 rounds both Q28 factors to Q21 first. The second lane only
    // serves Y(4,4), whose subtracted product is formed with a negated factor.
    always_comb
    begin
        t_x2 = COMB_W'(x2_reg);
        t_y2 = COMB_W'(y2_reg);
        t_z2 = COMB_W'(z2_reg);
        c_xmy  = t_x2 - t_y2;
        c_3xmy = 3 * t_x2 - t_y2;
        c_xm3y = t_x2 - 3 * t_y2;
        c_ym3x = t_y2 - 3 * t_x2;
        c_4z   = 4 * t_z2 - t_x2 - t_y2;
        c_2z3  = 2 * t_z2 - 3 * t_x2 - 3 * t_y2;
        c_2z   = 2 * t_z2 - t_x2 - t_y2;
        c_7z1  = 7 * t_z2 - ONE_Q28;
        c_7z3  = 7 * t_z2 - 3 * ONE_Q28;
        c_35z  = 35 * t_z2 - 30 * ONE_Q28;

        fa = '0;
        fb = '0;
        fc = '0;
        fd = '0;
        unique case (idx)
            SH_Y00:  begin fa = COMB_W'(16384);  fb = ONE_Q28;             end
            SH_Y1N1: begin fa = COMB_W'(y_reg);  fb = ONE_Q28;             end
            SH_Y10:  begin fa = COMB_W'(z_reg);  fb = ONE_Q28;             end
            SH_Y1P1: begin fa = COMB_W'(x_reg);  fb = ONE_Q28;             end
            SH_Y2N2: begin fa = COMB_W'(16384);  fb = COMB_W'(xy_reg);     end
            SH_Y2N1: begin fa = COMB_W'(16384);  fb = COMB_W'(yz_reg);     end
            SH_Y20:  begin fa = COMB_W'(16384);  fb = c_2z;                end
            SH_Y2P1: begin fa = COMB_W'(16384);  fb = COMB_W'(xz_reg);     end
            SH_Y2P2: begin fa = COMB_W'(16384);  fb = c_xmy;               end
            SH_Y3N3: begin fa = COMB_W'(y_reg);  fb = c_3xmy;              end
            SH_Y3N2: begin fa = COMB_W'(z_reg);  fb = COMB_W'(xy_reg);     end
            SH_Y3N1: begin fa = COMB_W'(y_reg);  fb = c_4z;                end
            SH_Y30:  begin fa = COMB_W'(z_reg);  fb = c_2z3;               end
            SH_Y3P1: begin fa = COMB_W'(x_reg);  fb = c_4z;                end
            SH_Y3P2: begin fa = COMB_W'(z_reg);  fb = c_xmy;               end
            SH_Y3P3: begin fa = COMB_W'(x_reg);  fb = c_xm3y;              end
            SH_Y4N4: begin fa = COMB_W'(xy_reg); fb = c_xmy;               end
            SH_Y4N3: begin fa = COMB_W'(yz_reg); fb = c_3xmy;              end
            SH_Y4N2: begin fa = COMB_W'(xy_reg); fb = c_7z1;               end
            SH_Y4N1: begin fa = COMB_W'(yz_reg); fb = c_7z3;               end
            SH_Y40:  begin fa = t_z2;            fb = c_35z;               end
            SH_Y4P1: begin fa = COMB_W'(xz_reg); fb = c_7z3;               end
            SH_Y4P2: begin fa = c_xmy;           fb = c_7z1;               end
            SH_Y4P3: begin fa = COMB_W'(xz_reg); fb = c_xm3y;              end
            SH_Y4P4:
            begin
                fa = t_x2;
                fb = c_xm3y;
                fc = t_y2;
                fd = c_ym3x;
            end
            default: begin fa = '0; fb = '0; end
        endcase

        ra = rnd7(fa);
        rb = rnd7(fb);
        rc = rnd7(fc);
        rd = rnd7(fd);
        opa_next = band4 ? ra[OPA_W-1:0] : fa[OPA_W-1:0];
        opb_next = band4 ? rb[OPB_W-1:0] : fb[OPB_W-1:0];
        opc_next = rc[OPA_W-1:0];
        opd_next = rd[OPB_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            opa_reg <= opa_next;
            opb_reg <= opb_next;
            opc_reg <= opc_next;
            opd_reg <= opd_next;
        end
    end

    // Stages 3 and 4: two multiplier lanes with rounding to Q28.
    rsh_lane u_lane_a (
        .clk      (clk),
        .mul_en   (adv[2]),
        .rnd_en   (adv[3]),
        .op_a     (opa_reg),
        .op_b     (opb_reg),
        .prod_rnd (pa)
    );

    rsh_lane u_lane_b (
        .clk      (clk),
        .mul_en   (adv[2]),
        .rnd_en   (adv[3]),
        .op_a     (opc_reg),
        .op_b     (opd_reg),
        .prod_rnd (pb)
    );

    // Stage 5: sum the lanes, add the constant term of Y(4,0), and clamp.
    // Every coefficient is at least 110925 in magnitude, so any polynomial
    // beyond 2^33 saturates the output, and clamping it there changes
    // nothing in the result.
    always_comb
    begin
        sum = SUM_W'(pa) + SUM_W'(pb)
              + ((idx == SH_Y40) ? SUM_W'(3 * ONE_Q28) : SUM_W'(0));
        if (sum > SUM_W'((64'sd1 <<< (POLY_W - 1)) - 64'sd1))
        begin
            poly_next = {1'b0, {(POLY_W-1){1'b1}}};
        end
        else if (sum < -SUM_W'(64'sd1 <<< (POLY_W - 1)))
        begin
            poly_next = {1'b1, {(POLY_W-1){1'b0}}};
        end
        else
        begin
            poly_next = sum[POLY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            poly_reg <= poly_next;
        end
    end

    // Stage 6: coefficient times polynomial, Q48.
    assign fin_next = FIN_W'(coef_of(idx)) * FIN_W'(poly_reg);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            fin_reg <= fin_next;
        end
    end

    // Stage 7: round Q48 to Q16, half away from zero, then saturate.
    always_comb
    begin
        fmag = fin_reg[FIN_W-1] ? ((FIN_W+1)'(0) - {fin_reg[FIN_W-1], fin_reg})
                                : {fin_reg[FIN_W-1], fin_reg};
        fr = (fmag + ((FIN_W+1)'(1) << 31)) >> 32;
        if (!fin_reg[FIN_W-1])
        begin
            if (fr > (FIN_W+1)'(131071))
            begin
                result_next.basis_value = VAL_W'(131071);
            end
            else
            begin
                result_next.basis_value = $signed(fr[VAL_W-1:0]);
            end
        end
        else
        begin
            if (fr > (FIN_W+1)'(131072))
            begin
                result_next.basis_value = -VAL_W'(131072);
            end
            else
            begin
                result_next.basis_value = $signed(VAL_W'(0) - fr[VAL_W-1:0]);
            end
        end
        result_next.bad_order = !ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/rsh_checker.sv
// Port-level checker for the spherical harmonic evaluator, with its bind statement.
`include "assert_macros.svh"

module rsh_checker
    import rsh_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input basis_res_t result,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A waiting result transaction holds until it is taken.
    `ASSERT_CLK(a_result_hold, clk, rst_n, (result_valid && result_stall |=> result_valid && $stable(result)), "result changed while stalled")

    // A rejected order always reports a zero value.
    `ASSERT_CLK(a_bad_zero, clk, rst_n, (result_valid && result.bad_order |-> result.basis_value == '0), "bad order with nonzero value")

    // With no result waiting the pipeline has room, so input is never stalled.
    `ASSERT_CLK(a_room, clk, rst_n, (!result_valid |-> !item_stall), "input stalled with empty output")

    // Without back pressure an accepted item passes every stage and reaches the output.
    `ASSERT_CLK(a_latency, clk, rst_n, (item_valid && !item_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall |=> result_valid), "result missing after pipeline latency")

    // The configuration port takes every write.
    `ASSERT_ALWAYS(a_cfg_ready, clk, rst_n, (!cfg_valid || cfg_ready), "configuration write refused")

endmodule

bind real_sph_harmonic_eval rsh_checker u_rsh_checker (.*);

### bench/tb_real_sph_harmonic_eval.sv
// Self-checking testbench for the real spherical harmonic evaluator, bands 0 to 4.
`timescale 1ns / 1ps

module tb_real_sph_harmonic_eval;
    import rsh_pkg::*;

    // The block is instantiated with its default band limit.
    localparam int     MAX_DEG     = MAX_DEGREE_DEF;
    localparam longint UNIT_Q28    = longint'(1) << 28;
    localparam longint VAL_MAX     = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint VAL_MIN     = -(longint'(1) << (VAL_W - 1));
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int     LONG_HOLD   = 60;
    // Cycles to keep watching the result channel once nothing is pending.
    localparam int     TAIL_CYCLES = 4 * NSTG;
    localparam int     TIMEOUT_NS  = 400000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    dir_item_t             item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    basis_res_t            result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_DEGREE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Shadow copy of the two configuration registers, as last written.
    logic [DEG_W-1:0]        cur_degree = '0;
    logic signed [ORD_W-1:0] cur_order  = '0;

    // Predicted results of accepted directions, oldest first.
    basis_res_t pending_basis[$];
    basis_res_t oldest_basis;

    int unsigned mismatch_count = 0;
    int unsigned dirs_sent      = 0;
    int unsigned basis_checked  = 0;
    int unsigned settings_used  = 0;

    // When set, neither side inserts random idle cycles.
    bit          no_idle    = 1'b0;
    // Set by a test to start one long receiver hold-off; the receiver clears it.
    bit          hold_go    = 1'b0;
    int unsigned hold_count = 0;

    real_sph_harmonic_eval i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rounds v / 2^s to nearest, with ties away from zero.
    function automatic longint round_half_away(input longint v, input int unsigned s);
        logic [63:0] mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Band 4 product: both Q28 factors go to Q21, the Q42 product back to Q28.
    function automatic longint prod_q21(input longint a, input longint b);
        return round_half_away(round_half_away(a, 7) * round_half_away(b, 7), 14);
    endfunction

    // Computes the basis value and the bad_order flag for one direction under
    // the given register contents. All polynomials are formed in Q28, the
    // coefficients are Q20, and the final Q48 product is rounded to Q16.
    function automatic basis_res_t predict_basis(input logic [DEG_W-1:0] deg,
                                                 input logic signed [ORD_W-1:0] ord,
                                                 input dir_item_t d);
        longint           x, y, z, x2, y2, z2, c, p, v;
        int               l, m;
        logic [IDX_W-1:0] code;
        basis_res_t       r;
        x  = longint'($signed(d.dir_x));
        y  = longint'($signed(d.dir_y));
        z  = longint'($signed(d.dir_z));
        x2 = x * x;
        y2 = y * y;
        z2 = z * z;
        l  = int'(deg);
        m  = int'(ord);
        r.basis_value = '0;
        r.bad_order   = 1'b1;
        // An order outside the band, or a band above the limit, is not evaluable.
        if (l > MAX_DEG || m < -l || m > l)
        begin
            return r;
        end
        code = IDX_W'(l * 9 + m + 4);
        case (code)
            SH_Y00:  begin c = 295798;   p = UNIT_Q28; end
            SH_Y1N1: begin c = -512337;  p = y * 16384; end
            SH_Y10:  begin c = 512337;   p = z * 16384; end
            SH_Y1P1: begin c = -512337;  p = x * 16384; end
            SH_Y2N2: begin c = 1145620;  p = x * y; end
            SH_Y2N1: begin c = -1145620; p = y * z; end
            SH_Y20:  begin c = 330712;   p = 2 * z2 - x2 - y2; end
            SH_Y2P1: begin c = -1145620; p = x * z; end
            SH_Y2P2: begin c = 572810;   p = x2 - y2; end
            SH_Y3N3: begin c = -618706;  p = round_half_away(y * (3 * x2 - y2), 14); end
            SH_Y3N2: begin c = 3031025;  p = round_half_away(x * y * z, 14); end
            SH_Y3N1: begin c = -479247;  p = round_half_away(y * (4 * z2 - x2 - y2), 14); end
            SH_Y30:
            begin
                c = 391303;
                p = round_half_away(z * (2 * z2 - 3 * x2 - 3 * y2), 14);
            end
            SH_Y3P1: begin c = -479247;  p = round_half_away(x * (4 * z2 - x2 - y2), 14); end
            SH_Y3P2: begin c = 1515513;  p = round_half_away(z * (x2 - y2), 14); end
            SH_Y3P3: begin c = -618706;  p = round_half_away(x * (x2 - 3 * y2), 14); end
            SH_Y4N4: begin c = 2624945;  p = prod_q21(x * y, x2 - y2); end
            SH_Y4N3: begin c = -1856117; p = prod_q21(y * z, 3 * x2 - y2); end
            SH_Y4N2: begin c = 992136;   p = prod_q21(x * y, 7 * z2 - UNIT_Q28); end
            SH_Y4N1: begin c = -701547;  p = prod_q21(y * z, 7 * z2 - 3 * UNIT_Q28); end
            SH_Y40:
            begin
                c = 110925;
                p = prod_q21(z2, 35 * z2 - 30 * UNIT_Q28) + 3 * UNIT_Q28;
            end
            SH_Y4P1: begin c = -701547;  p = prod_q21(x * z, 7 * z2 - 3 * UNIT_Q28); end
            SH_Y4P2: begin c = 496068;   p = prod_q21(x2 - y2, 7 * z2 - UNIT_Q28); end
            SH_Y4P3: begin c = -1856117; p = prod_q21(x * z, x2 - 3 * y2); end
            SH_Y4P4:
            begin
                // Each of the two band 4 products is rounded on its own.
                c = 656237;
                p = prod_q21(x2, x2 - 3 * y2) - prod_q21(y2, 3 * x2 - y2);
            end
            default: return r;
        endcase
        v = round_half_away(c * p, 32);
        if (v > VAL_MAX)
        begin
            v = VAL_MAX;
        end
        if (v < VAL_MIN)
        begin
            v = VAL_MIN;
        end
        r.basis_value = VAL_W'(v);
        r.bad_order   = 1'b0;
        return r;
    endfunction

    // Random direction: mostly unit vectors, then arbitrary in-range triples,
    // then raw 16-bit patterns that are far from unit and drive saturation.
    function automatic dir_item_t random_dir();
        int        sel, rot;
        real       rx, ry, rz, rr;
        int        cx, cy, cz;
        dir_item_t d;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            do
            begin
                rx = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
                ry = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
                rr = rx * rx + ry * ry;
            end
            while (rr > 1.0);
            rz = $sqrt(1.0 - rr);
            if ($urandom_range(1) == 1)
            begin
                rz = -rz;
            end
            cx = $rtoi(rx * 16384.0);
            cy = $rtoi(ry * 16384.0);
            cz = $rtoi(rz * 16384.0);
            // Rotate the axes so the large component is not always z.
            rot = $urandom_range(2);
            if (rot == 0)
            begin
                d.dir_x = DIR_W'(cx); d.dir_y = DIR_W'(cy); d.dir_z = DIR_W'(cz);
            end
            else if (rot == 1)
            begin
                d.dir_x = DIR_W'(cz); d.dir_y = DIR_W'(cx); d.dir_z = DIR_W'(cy);
            end
            else
            begin
                d.dir_x = DIR_W'(cy); d.dir_y = DIR_W'(cz); d.dir_z = DIR_W'(cx);
            end
        end
        else if (sel < 85)
        begin
            d.dir_x = DIR_W'(int'($urandom_range(32768)) - 16384);
            d.dir_y = DIR_W'(int'($urandom_range(32768)) - 16384);
            d.dir_z = DIR_W'(int'($urandom_range(32768)) - 16384);
        end
        else
        begin
            d.dir_x = DIR_W'($urandom());
            d.dir_y = DIR_W'($urandom());
            d.dir_z = DIR_W'($urandom());
        end
        return d;
    endfunction

    // Prints one line per mismatch and keeps count.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offers one direction and waits until the block takes it. The prediction
    // is made at the accepting edge, with the registers as they stand.
    task automatic send_dir(input dir_item_t d);
        while (!no_idle && $urandom_range(99) < 11)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= d;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        pending_basis.push_back(predict_basis(cur_degree, cur_order, d));
        dirs_sent++;
    endtask

    // Stops offering directions and waits until every predicted result has
    // been taken. Always advances at least one clock.
    task automatic wait_results_drained();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_basis.size() != 0);
    endtask

    // Writes degree and then order on the configuration channel; valid stays
    // high between the two transactions. The block must be idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] deg_data,
                              input logic [CFG_DATA_W-1:0] ord_data);
        cfg_index <= CFG_DEGREE;
        cfg_data  <= deg_data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_degree = deg_data[DEG_W-1:0];
        cfg_index <= CFG_ORDER;
        cfg_data  <= ord_data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_order = $signed(ord_data[ORD_W-1:0]);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Checks every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_basis.size() == 0)
            begin
                report_mismatch("result transaction with no prediction pending");
            end
            else
            begin
                oldest_basis = pending_basis.pop_front();
                if (result.basis_value !== oldest_basis.basis_value)
                begin
                    report_mismatch($sformatf(
                        "basis_value got %0d expected %0d (degree %0d order %0d)",
                        $signed(result.basis_value), $signed(oldest_basis.basis_value),
                        cur_degree, cur_order));
                end
                if (result.bad_order !== oldest_basis.bad_order)
                begin
                    report_mismatch($sformatf(
                        "bad_order got %b expected %b (degree %0d order %0d)",
                        result.bad_order, oldest_basis.bad_order, cur_degree, cur_order));
                end
                basis_checked++;
            end
        end
    end

    // Receiver: random stall with a chance of about 11 in a hundred, or a solid
    // hold-off counted down from LONG_HOLD when a test asks for one. The
    // hold-off is counted here so the sender can keep offering items meanwhile.
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go    = 1'b0;
            hold_count = LONG_HOLD;
        end
        if (hold_count != 0)
        begin
            hold_count--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !no_idle && ($urandom_range(99) < 11);
        end
    end

    // The registers as they come out of reset select Y(0,0).
    task automatic test_reset_config();
        dir_item_t d;
        d.dir_x = 16'sd0;
        d.dir_y = 16'sd0;
        d.dir_z = 16'sd16384;
        send_dir(d);
    endtask

    // One transaction for each of the 25 basis functions, with directions
    // that cycle through the axis extremes, a diagonal and full-scale patterns.
    task automatic test_every_basis();
        dir_item_t corners[10];
        int        k;
        corners[0] = {16'sd16384,  16'sd0,      16'sd0};
        corners[1] = {-16'sd16384, 16'sd0,      16'sd0};
        corners[2] = {16'sd0,      16'sd16384,  16'sd0};
        corners[3] = {16'sd0,      -16'sd16384, 16'sd0};
        corners[4] = {16'sd0,      16'sd0,      16'sd16384};
        corners[5] = {16'sd0,      16'sd0,      -16'sd16384};
        corners[6] = {16'sd9459,   16'sd9459,   16'sd9459};
        corners[7] = {16'h8000,    16'h8000,    16'h8000};
        corners[8] = {16'h7FFF,    16'h7FFF,    16'h7FFF};
        corners[9] = {16'sd11585,  -16'sd11585, 16'sd0};
        k = 0;
        for (int l = 0; l <= MAX_DEG; l++)
        begin
            for (int m = -l; m <= l; m++)
            begin
                wait_results_drained();
                set_config(CFG_DATA_W'(l), CFG_DATA_W'(m));
                send_dir(corners[k % 10]);
                k++;
            end
        end
    endtask

    // Orders outside the band and degrees above the limit give a flagged zero.
    // The ignored top bit of the degree data is set once here.
    task automatic test_out_of_band();
        dir_item_t d;
        d = {16'sd9459, 16'sd9459, 16'sd9459};
        wait_results_drained();
        set_config(CFG_DATA_W'(1), CFG_DATA_W'(3));
        send_dir(d);
        wait_results_drained();
        set_config(CFG_DATA_W'(15), CFG_DATA_W'(0));
        send_dir(d);
        wait_results_drained();
        set_config(CFG_DATA_W'(4), CFG_DATA_W'(-8));
        send_dir(d);
    endtask

    // Picks a register setting: mostly valid pairs, sometimes anything.
    task automatic pick_random_setting();
        int deg, ord;
        logic [CFG_DATA_W-1:0] deg_data;
        if ($urandom_range(99) < 75)
        begin
            deg = $urandom_range(MAX_DEG);
            ord = int'($urandom_range(2 * deg)) - deg;
        end
        else
        begin
            deg = $urandom_range(7);
            ord = $urandom_range(15);
        end
        deg_data = CFG_DATA_W'(deg);
        if ($urandom_range(99) < 20)
        begin
            deg_data[CFG_DATA_W-1] = 1'b1;
        end
        wait_results_drained();
        set_config(deg_data, CFG_DATA_W'(ord));
    endtask

    // A long stretch at full rate with no idling on either side.
    task automatic test_no_idle_stretch(input int n_items);
        pick_random_setting();
        no_idle = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            send_dir(random_dir());
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the pipeline
    // fills and item_stall rises. Then the sender pauses until all results
    // are back before going on.
    task automatic test_backpressure(input int n_items);
        pick_random_setting();
        no_idle = 1'b1;
        hold_go = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            send_dir(random_dir());
        end
        no_idle = 1'b0;
        wait_results_drained();
        for (int i = 0; i < 8; i++)
        begin
            send_dir(random_dir());
        end
    endtask

    // Random phases, each with its own register setting and a random length.
    task automatic test_random_phases(input int n_items);
        int sent, phase_len;
        sent = 0;
        while (sent < n_items)
        begin
            pick_random_setting();
            phase_len = $urandom_range(20, 70);
            for (int i = 0; i < phase_len && sent < n_items; i++)
            begin
                send_dir(random_dir());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_every_basis();
        test_out_of_band();
        test_no_idle_stretch(150);
        test_backpressure(40);
        test_random_phases(720);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d directions and %0d results over %0d register settings.",
                 dirs_sent, basis_checked, settings_used);
        $display("Settings spanned all 25 basis functions, out-of-band orders and degrees %s",
                 "above the limit; inputs included non-unit patterns and backpressure.");
        if (mismatch_count == 0)
        begin
            $display("[real_sph_harmonic_eval] OK");
        end
        else
        begin
            $display("[real_sph_harmonic_eval] ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending.", pending_basis.size());
        $display("[real_sph_harmonic_eval] ERROR");
        $finish;
    end

endmodule
